/* rtl/core/ilsm_pkg.sv */
package ilsm_pkg;

    localparam int TIME_W   = 48;
    localparam int DUR_W    = 39;
    localparam int MAX_W    = 38;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 32;
    localparam int LINE_W   = 8;
    localparam int CPUF_W   = 3;
    localparam int OP_W     = 2;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 208;
    localparam int M_USER_W = 2;

    localparam int NS_PER_US    = 1000;
    localparam int REM_W        = 11;
    localparam int HALF_W       = 24;
    localparam int RCP_W        = 41;
    localparam int RCP_LO_W     = 21;
    localparam int PROD_W       = 45;
    localparam int ACC_W        = 89;
    localparam int RCP_SHIFT    = 50;
    localparam int MUL_STEPS    = 4;
    localparam int DIV_STEPS    = 6;
    localparam int DIV_CNT_W    = 3;

    localparam logic [RCP_W-1:0] RCP_MUL = 41'd1125899906842;

    localparam logic [CFG_W-1:0] LONG_IRQ_RST  = 32'd500;
    localparam logic [CFG_W-1:0] LONG_SOFT_RST = 32'd10000;
    localparam logic [CFG_W-1:0] STORM_GAP_RST = 32'd500;

    localparam logic [1:0] REG_LONG_IRQ  = 2'd0;
    localparam logic [1:0] REG_LONG_SOFT = 2'd1;
    localparam logic [1:0] REG_STORM_GAP = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_IRQ_BEGIN  = 2'd0,
        OP_IRQ_END    = 2'd1,
        OP_SOFT_BEGIN = 2'd2,
        OP_SOFT_END   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_WRITE
    } ctl_state_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic rd_en;
        logic div_load;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [CFG_W-1:0] hard_limit;
        logic [CFG_W-1:0] long_soft;
        logic [CFG_W-1:0] storm_gap;
    } cfg_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

/* rtl/core/ilsm_ctrl.sv */
module ilsm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ilsm_pkg::stat_t stat,
    output ilsm_pkg::cmd_t  cmd
);

    ilsm_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ilsm_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ilsm_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) begin
                    state_next = ilsm_pkg::ST_IDLE;
                end
            end
            ilsm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ilsm_pkg::ST_READ;
                end
            end
            ilsm_pkg::ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ilsm_pkg::ST_LOAD;
            end
            ilsm_pkg::ST_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ilsm_pkg::ST_DIV;
            end
            ilsm_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ilsm_pkg::ST_WRITE;
                end
            end
            ilsm_pkg::ST_WRITE: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ilsm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ilsm_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/core/ilsm_datapath.sv */
module ilsm_datapath #(
    parameter int NUM_CPUS         = 8,
    parameter int NUM_LINES        = 64,
    parameter int NUM_SOFT_VECTORS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ilsm_pkg::cmd_t                     cmd,
    output ilsm_pkg::stat_t                    stat,
    input  ilsm_pkg::cfg_t                     cfg,
    input  logic [ilsm_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic [ilsm_pkg::OP_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ilsm_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [ilsm_pkg::M_USER_W-1:0]      m_tuser
);

    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int LN_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int SV_W  = (NUM_SOFT_VECTORS > 1) ? $clog2(NUM_SOFT_VECTORS) : 1;
    localparam int IB_D  = NUM_CPUS * NUM_LINES;
    localparam int SB_D  = NUM_CPUS * NUM_SOFT_VECTORS;
    localparam int IB_W  = (IB_D > 1) ? $clog2(IB_D) : 1;
    localparam int SB_W  = (SB_D > 1) ? $clog2(SB_D) : 1;
    localparam int CLR_D = (IB_D > SB_D) ? IB_D : SB_D;
    localparam int CLR_W = (CLR_D > 1) ? $clog2(CLR_D) : 1;
    localparam int TW    = ilsm_pkg::TIME_W;
    localparam int DW    = ilsm_pkg::DUR_W;
    localparam int MW    = ilsm_pkg::MAX_W;
    localparam int CW    = ilsm_pkg::CNT_W;
    localparam int HW    = ilsm_pkg::HALF_W;
    localparam int RW    = ilsm_pkg::REM_W;
    localparam int LW    = ilsm_pkg::RCP_LO_W;
    localparam int PW    = ilsm_pkg::PROD_W;
    localparam int AW    = ilsm_pkg::ACC_W;

    logic [TW-1:0] ib_mem [IB_D];
    logic [TW-1:0] sb_mem [SB_D];
    logic [TW-1:0] lb_mem [NUM_LINES];
    logic [MW-1:0] im_mem [NUM_LINES];
    logic [CW-1:0] sc_mem [NUM_LINES];
    logic [CW-1:0] sp_mem [NUM_LINES];
    logic [MW-1:0] sm_mem [NUM_SOFT_VECTORS];

    logic [CW-1:0] irq_cpu_reg  [NUM_CPUS];
    logic [CW-1:0] soft_cpu_reg [NUM_CPUS];
    logic [CW-1:0] irq_tot_reg, soft_tot_reg;

    logic [CLR_W-1:0] clr_cnt_reg;

    ilsm_pkg::op_t                  op_reg;
    logic [ilsm_pkg::CPUF_W-1:0]    cpu_reg;
    logic [ilsm_pkg::LINE_W-1:0]    line_reg;
    logic [TW-1:0]                  time_reg;
    logic                           ign_reg;

    logic [TW-1:0] ib_rd_reg, sb_rd_reg, lb_rd_reg;
    logic [MW-1:0] im_rd_reg, sm_rd_reg;
    logic [CW-1:0] sc_rd_reg, sp_rd_reg;

    logic [TW-1:0]                  num_reg;
    logic [AW-1:0]                  acc_reg;
    logic [RW-1:0]                  rem_reg;
    logic [DW-1:0]                  quo_reg;
    logic [ilsm_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic                          m_tvalid_reg;
    logic [ilsm_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [ilsm_pkg::M_USER_W-1:0] m_tuser_reg;

    logic [CPU_W-1:0] cpu_l;
    logic [LN_W-1:0]  ln_l;
    logic [SV_W-1:0]  sv_l;
    logic [IB_W-1:0]  ib_idx;
    logic [SB_W-1:0]  sb_idx;
    logic             hard;
    logic             ign_in;
    logic [TW-1:0]    then_t;
    logic [TW-1:0]    diff;
    logic [HW-1:0]    mul_a;
    logic [LW-1:0]    mul_b;
    logic [PW-1:0]    prod;
    logic [AW-1:0]    acc_add;
    logic [DW-1:0]    quo_est;
    logic [RW-1:0]    rem_est;

    logic          is_long;
    logic [DW-1:0] dur_o;
    logic [MW-1:0] max_new;
    logic [MW-1:0] dur_sat;
    logic [CW-1:0] tot_new, cpu_new, sc_new, sp_new;
    logic [CW-1:0] cur_tot, cur_cpu;

    assign hard   = (s_tuser == ilsm_pkg::OP_IRQ_BEGIN) || (s_tuser == ilsm_pkg::OP_IRQ_END);
    assign ign_in = (32'(s_tdata[10:3]) >= (hard ? NUM_LINES : NUM_SOFT_VECTORS)) ||
                    (32'(s_tdata[2:0]) >= NUM_CPUS);

    assign cpu_l  = CPU_W'(cpu_reg);
    assign ln_l   = LN_W'(line_reg);
    assign sv_l   = SV_W'(line_reg);
    assign ib_idx = IB_W'(cpu_l) * IB_W'(NUM_LINES) + IB_W'(line_reg);
    assign sb_idx = SB_W'(cpu_l) * SB_W'(NUM_SOFT_VECTORS) + SB_W'(line_reg);

    assign stat.clr_done = (32'(clr_cnt_reg) == CLR_D - 1);
    assign stat.div_done = (32'(div_cnt_reg) == ilsm_pkg::DIV_STEPS - 1);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step && !stat.clr_done) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= ilsm_pkg::op_t'(s_tuser);
            cpu_reg  <= s_tdata[2:0];
            line_reg <= s_tdata[10:3];
            time_reg <= s_tdata[58:11];
            ign_reg  <= ign_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            ib_rd_reg <= ib_mem[ib_idx];
            sb_rd_reg <= sb_mem[sb_idx];
            lb_rd_reg <= lb_mem[ln_l];
            im_rd_reg <= im_mem[ln_l];
            sc_rd_reg <= sc_mem[ln_l];
            sp_rd_reg <= sp_mem[ln_l];
            sm_rd_reg <= sm_mem[sv_l];
        end
    end

    always_comb begin
        case (op_reg)
            ilsm_pkg::OP_IRQ_BEGIN: then_t = lb_rd_reg;
            ilsm_pkg::OP_IRQ_END:   then_t = ib_rd_reg;
            ilsm_pkg::OP_SOFT_END:  then_t = sb_rd_reg;
            default:                then_t = time_reg;
        endcase
        diff = (time_reg < then_t) ? '0 : time_reg - then_t;
    end

    // reciprocal multiply by 2^50/1000 in four partial products, then one fixup
    always_comb begin
        mul_a = div_cnt_reg[1] ? num_reg[TW-1:HW] : num_reg[HW-1:0];
        mul_b = div_cnt_reg[0] ? LW'(ilsm_pkg::RCP_MUL[ilsm_pkg::RCP_W-1:LW])
                               : ilsm_pkg::RCP_MUL[LW-1:0];
        prod  = PW'(mul_a) * PW'(mul_b);
        case (div_cnt_reg)
            3'd0:    acc_add = AW'(prod);
            3'd1:    acc_add = AW'(prod) << LW;
            3'd2:    acc_add = AW'(prod) << HW;
            3'd3:    acc_add = AW'(prod) << (HW + LW);
            default: acc_add = '0;
        endcase
        quo_est = acc_reg[AW-1:ilsm_pkg::RCP_SHIFT];
        rem_est = RW'(num_reg) - RW'(quo_est * DW'(ilsm_pkg::NS_PER_US));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_load) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            num_reg <= diff;
            acc_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            if (32'(div_cnt_reg) < ilsm_pkg::MUL_STEPS) begin
                acc_reg <= acc_reg + acc_add;
            end else if (32'(div_cnt_reg) == ilsm_pkg::MUL_STEPS) begin
                quo_reg <= quo_est;
                rem_reg <= rem_est;
            end else if (rem_reg >= RW'(ilsm_pkg::NS_PER_US)) begin
                quo_reg <= quo_reg + 1'b1;
            end
        end
    end

    always_comb begin
        is_long = 1'b0;
        dur_o   = '0;
        sc_new  = sc_rd_reg;
        sp_new  = sp_rd_reg;
        dur_sat = quo_reg[DW-1] ? '1 : quo_reg[MW-1:0];
        max_new = (op_reg == ilsm_pkg::OP_SOFT_END) ? sm_rd_reg : im_rd_reg;
        cur_tot = (op_reg == ilsm_pkg::OP_IRQ_BEGIN || op_reg == ilsm_pkg::OP_IRQ_END)
                  ? irq_tot_reg : soft_tot_reg;
        cur_cpu = (op_reg == ilsm_pkg::OP_IRQ_BEGIN || op_reg == ilsm_pkg::OP_IRQ_END)
                  ? irq_cpu_reg[cpu_l] : soft_cpu_reg[cpu_l];
        case (op_reg)
            ilsm_pkg::OP_IRQ_BEGIN: begin
                if (quo_reg <= DW'(cfg.storm_gap)) begin
                    sc_new = ilsm_pkg::sat_inc(sc_rd_reg);
                end else begin
                    sp_new = (sc_rd_reg > sp_rd_reg) ? sc_rd_reg : sp_rd_reg;
                    sc_new = '0;
                end
            end
            ilsm_pkg::OP_IRQ_END: begin
                dur_o   = quo_reg;
                is_long = quo_reg >= DW'(cfg.hard_limit);
                max_new = (dur_sat > im_rd_reg) ? dur_sat : im_rd_reg;
            end
            ilsm_pkg::OP_SOFT_BEGIN: begin
                max_new = sm_rd_reg;
            end
            ilsm_pkg::OP_SOFT_END: begin
                dur_o   = quo_reg;
                is_long = quo_reg >= DW'(cfg.long_soft);
                max_new = (dur_sat > sm_rd_reg) ? dur_sat : sm_rd_reg;
            end
            default: begin
                dur_o = '0;
            end
        endcase
        tot_new = is_long ? ilsm_pkg::sat_inc(cur_tot) : cur_tot;
        cpu_new = is_long ? ilsm_pkg::sat_inc(cur_cpu) : cur_cpu;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            if (32'(clr_cnt_reg) < IB_D) begin
                ib_mem[clr_cnt_reg[IB_W-1:0]] <= '0;
            end
            if (32'(clr_cnt_reg) < SB_D) begin
                sb_mem[clr_cnt_reg[SB_W-1:0]] <= '0;
            end
            if (32'(clr_cnt_reg) < NUM_LINES) begin
                lb_mem[clr_cnt_reg[LN_W-1:0]] <= '0;
                im_mem[clr_cnt_reg[LN_W-1:0]] <= '0;
                sc_mem[clr_cnt_reg[LN_W-1:0]] <= '0;
                sp_mem[clr_cnt_reg[LN_W-1:0]] <= '0;
            end
            if (32'(clr_cnt_reg) < NUM_SOFT_VECTORS) begin
                sm_mem[clr_cnt_reg[SV_W-1:0]] <= '0;
            end
        end else if (cmd.commit && !ign_reg) begin
            case (op_reg)
                ilsm_pkg::OP_IRQ_BEGIN: begin
                    ib_mem[ib_idx] <= time_reg;
                    lb_mem[ln_l]   <= time_reg;
                    sc_mem[ln_l]   <= sc_new;
                    sp_mem[ln_l]   <= sp_new;
                end
                ilsm_pkg::OP_IRQ_END: begin
                    im_mem[ln_l] <= max_new;
                end
                ilsm_pkg::OP_SOFT_BEGIN: begin
                    sb_mem[sb_idx] <= time_reg;
                end
                ilsm_pkg::OP_SOFT_END: begin
                    sm_mem[sv_l] <= max_new;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_tot_reg  <= '0;
            soft_tot_reg <= '0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                irq_cpu_reg[i]  <= '0;
                soft_cpu_reg[i] <= '0;
            end
        end else if (cmd.commit && !ign_reg && is_long) begin
            if (op_reg == ilsm_pkg::OP_IRQ_END) begin
                irq_tot_reg        <= tot_new;
                irq_cpu_reg[cpu_l] <= cpu_new;
            end else begin
                soft_tot_reg        <= tot_new;
                soft_cpu_reg[cpu_l] <= cpu_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (ign_reg) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 2'b01;
            end else begin
                m_tuser_reg <= {is_long, 1'b0};
                m_tdata_reg[38:0]    <= dur_o;
                m_tdata_reg[77:39]   <= DW'(max_new);
                m_tdata_reg[109:78]  <= tot_new;
                m_tdata_reg[141:110] <= cpu_new;
                if (op_reg == ilsm_pkg::OP_IRQ_BEGIN || op_reg == ilsm_pkg::OP_IRQ_END) begin
                    m_tdata_reg[173:142] <= sc_new;
                    m_tdata_reg[205:174] <= sp_new;
                end else begin
                    m_tdata_reg[173:142] <= '0;
                    m_tdata_reg[205:174] <= '0;
                end
                m_tdata_reg[207:206] <= '0;
            end
        end
    end

endmodule

/* rtl/core/irq_latency_storm_monitor_unit.sv */
// Each item goes through read, load, the four partial products of the reciprocal multiply,
// an estimate step, a fixup step and write; the write waits while the output stalls.
// Items go one at a time through the shared divide-by-1000 unit; the next is taken after the write.
// A finished result waits in the output register while the next item is taken.
// Reset (aresetn low, synchronous) clears the long-event counters; then a clearing pass over
// max(NUM_CPUS*NUM_LINES, NUM_CPUS*NUM_SOFT_VECTORS) entries (512) runs before any item is taken.
module irq_latency_storm_monitor_unit #(
    parameter int NUM_CPUS         = 8,
    parameter int NUM_LINES        = 64,
    parameter int NUM_SOFT_VECTORS = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // cpu_id[2:0], line[10:3], time_ns[58:11]
    input  logic [1:0]   s_tuser,   // opcode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // duration_us[38:0], line_max_us[77:39], long_total[109:78],
    // long_on_cpu[141:110], storm_run[173:142], storm_max[205:174]
    output logic [207:0] m_tdata,
    output logic [1:0]   m_tuser,   // ignored[0], is_long[1]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    ilsm_pkg::cfg_t  cfg_reg;
    ilsm_pkg::cmd_t  cmd;
    ilsm_pkg::stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hard_limit <= ilsm_pkg::LONG_IRQ_RST;
            cfg_reg.long_soft  <= ilsm_pkg::LONG_SOFT_RST;
            cfg_reg.storm_gap  <= ilsm_pkg::STORM_GAP_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                ilsm_pkg::REG_LONG_IRQ:  cfg_reg.hard_limit <= pwdata;
                ilsm_pkg::REG_LONG_SOFT: cfg_reg.long_soft  <= pwdata;
                ilsm_pkg::REG_STORM_GAP: cfg_reg.storm_gap  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ilsm_pkg::REG_LONG_IRQ:  prdata = cfg_reg.hard_limit;
            ilsm_pkg::REG_LONG_SOFT: prdata = cfg_reg.long_soft;
            ilsm_pkg::REG_STORM_GAP: prdata = cfg_reg.storm_gap;
            default:                 prdata = '0;
        endcase
    end

    ilsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ilsm_datapath #(
        .NUM_CPUS         (NUM_CPUS),
        .NUM_LINES        (NUM_LINES),
        .NUM_SOFT_VECTORS (NUM_SOFT_VECTORS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/core/ilsm_checker.sv */
module ilsm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [207:0] m_tdata,
    input logic [1:0]   m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_ignored_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("ignored item carries nonzero fields");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ports active right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in work");

endmodule

bind irq_latency_storm_monitor_unit ilsm_checker u_ilsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
